### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the message block padder checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define HMBP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define HMBP_ASSERT_NEVER(label, clk, rst, expr, msg) \
   `HMBP_ASSERT(label, clk, rst, !(expr), msg)

`endif

### hdl/hmbp_pkg.sv
// ----------------------------------------------------------------------------
// Message block padder package
// Constants, phase codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package hmbp_pkg;

   localparam int DEF_MAX_BLOCK_BYTES = 128;
   localparam int LENGTH_FIELD_BYTES  = 8;
   localparam int WORD_INDEX_W        = 4;
   localparam int COUNT_W             = 64;

   localparam logic [7:0] PAD_MARK        = 8'h80;
   localparam logic [7:0] SMALL_LEN_START = 8'd56;
   localparam logic [7:0] BIG_LEN_START   = 8'd112;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic [1:0] PH_DATA       = 2'd0;
   localparam logic [1:0] PH_PAD        = 2'd1;
   localparam logic [1:0] PH_MARK_FINAL = 2'd2;
   localparam logic [1:0] PH_LEN_FINAL  = 2'd3;

   typedef struct packed {
      logic                    append;
      logic                    rd_en;
      logic                    load;
      logic                    clear;
      logic [1:0]              phase;
      logic                    last_word;
      logic [WORD_INDEX_W-1:0] word;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic two_blk;
      logic big;
   } status_type;

endpackage

### hdl/hmbp_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one message item: an operation code and a data byte.
// ----------------------------------------------------------------------------
interface hmbp_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink (input valid, input operation, input data_byte, output ready);
endinterface

### hdl/hmbp_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries one block word with its position and end markers.
// ----------------------------------------------------------------------------
interface hmbp_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_word;
   logic [3:0]  word_index;
   logic        last_of_block;
   logic        last_of_message;

   modport source (output valid, output block_word, output word_index,
                   output last_of_block, output last_of_message, input ready);
   modport sink (input valid, input block_word, input word_index,
                 input last_of_block, input last_of_message, output ready);
endinterface

### hdl/hmbp_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Write channel for the block size mode register.
// ----------------------------------------------------------------------------
interface hmbp_csr_if;
   logic valid;
   logic ready;
   logic block_size_mode;

   modport source (output valid, output block_size_mode, input ready);
   modport sink (input valid, input block_size_mode, output ready);
endinterface

### hdl/hmbp_ctrl.sv
// ----------------------------------------------------------------------------
// Message block padder controller
// Sequences byte appends and the word-by-word emission of blocks.
// ----------------------------------------------------------------------------
module hmbp_ctrl #(
   parameter int MAX_BLOCK_BYTES = hmbp_pkg::DEF_MAX_BLOCK_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   input  hmbp_pkg::status_type status,
   output hmbp_pkg::cmd_type    cmd
);
   import hmbp_pkg::*;

   localparam int PosW  = $clog2(MAX_BLOCK_BYTES);
   localparam int AddrW = PosW - 3;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_LOAD = 2'd2;
   localparam logic [1:0] S_SEND = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [AddrW-1:0] word_ff, word_in;
   logic [1:0]       phase_ff, phase_in;
   logic             last_word;

   assign last_word = (word_ff == (status.big ? {AddrW{1'b1}} : AddrW'(7)));

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      phase_in      = phase_ff;
      req_ready     = (state_ff == S_IDLE);
      rsp_valid     = (state_ff == S_SEND);
      cmd           = '0;
      cmd.word      = WORD_INDEX_W'(word_ff);
      cmd.phase     = phase_ff;
      cmd.last_word = last_word;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               word_in = '0;
               if (req_operation == OP_APPEND) begin
                  cmd.append = 1'b1;
                  if (status.full) begin
                     phase_in = PH_DATA;
                     state_in = S_READ;
                  end
               end else begin
                  phase_in = status.two_blk ? PH_PAD : PH_MARK_FINAL;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_SEND;
         end
         S_SEND: begin
            if (rsp_ready) begin
               if (!last_word) begin
                  word_in  = word_ff + AddrW'(1);
                  state_in = S_READ;
               end else if (phase_ff == PH_PAD) begin
                  phase_in = PH_LEN_FINAL;
                  word_in  = '0;
                  state_in = S_READ;
               end else begin
                  cmd.clear = (phase_ff inside {PH_MARK_FINAL, PH_LEN_FINAL});
                  state_in  = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         word_ff  <= '0;
         phase_ff <= PH_DATA;
      end else begin
         state_ff <= state_in;
         word_ff  <= word_in;
         phase_ff <= phase_in;
      end
   end

endmodule

### hdl/hmbp_dp.sv
// ----------------------------------------------------------------------------
// Message block padder datapath
// Block buffer, byte count, mode register and padded word formation.
// ----------------------------------------------------------------------------
module hmbp_dp #(
   parameter int MAX_BLOCK_BYTES = hmbp_pkg::DEF_MAX_BLOCK_BYTES
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  csr_write,
   input  logic                                  csr_block_size_mode,
   input  hmbp_pkg::cmd_type                     cmd,
   output hmbp_pkg::status_type                  status,
   output logic [63:0]                           rsp_block_word,
   output logic [hmbp_pkg::WORD_INDEX_W-1:0]     rsp_word_index,
   output logic                                  rsp_last_of_block,
   output logic                                  rsp_last_of_message
);
   import hmbp_pkg::*;

   localparam int   PosW     = $clog2(MAX_BLOCK_BYTES);
   localparam int   AddrW    = PosW - 3;
   localparam int   MemWords = 2 ** AddrW;
   localparam int   LenBits  = LENGTH_FIELD_BYTES * 8;
   localparam logic BigOk    = (MAX_BLOCK_BYTES >= 128);

   logic                 mode_ff;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [7:0][7:0]      mem_ff [MemWords];
   logic [7:0][7:0]      rd_ff;
   logic [7:0][7:0]      fill_word;
   logic [63:0]          block_word_ff;
   logic [WORD_INDEX_W-1:0] word_index_ff;
   logic                 last_of_block_ff;
   logic                 last_of_message_ff;

   logic                 big;
   logic [PosW-1:0]      mask;
   logic [PosW-1:0]      pos;
   logic [AddrW-1:0]     word;
   logic                 final_phase;
   logic [PosW-1:0]      byte_pos;
   logic [LenBits-1:0]   bit_count;

   assign big         = mode_ff & BigOk;
   assign mask        = big ? {PosW{1'b1}} : PosW'(63);
   assign pos         = count_ff[PosW-1:0] & mask;
   assign word        = cmd.word[AddrW-1:0];
   assign final_phase = (cmd.phase == PH_MARK_FINAL) || (cmd.phase == PH_LEN_FINAL);
   assign bit_count   = LenBits'({count_ff[COUNT_W-4:0], 3'b000});

   assign status.full    = (pos == mask);
   assign status.two_blk = (8'(pos) >= (big ? BIG_LEN_START : SMALL_LEN_START));
   assign status.big     = big;

   always_comb begin
      byte_pos  = '0;
      fill_word = rd_ff;
      if (cmd.phase != PH_DATA) begin
         for (int k = 0; k < 8; k++) begin
            byte_pos = {word, 3'(k)};
            if (cmd.phase == PH_LEN_FINAL || byte_pos > pos) begin
               fill_word[7-k] = 8'h00;
            end else if (byte_pos == pos) begin
               fill_word[7-k] = PAD_MARK;
            end
         end
         if (final_phase && cmd.last_word) begin
            fill_word = bit_count;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (csr_write) begin
            mode_ff <= csr_block_size_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem_ff[pos[PosW-1:3]][3'd7 - pos[2:0]] <= req_data_byte;
      end else if (cmd.load && cmd.phase != PH_DATA) begin
         mem_ff[word] <= fill_word;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem_ff[word];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         block_word_ff      <= fill_word;
         word_index_ff      <= cmd.word;
         last_of_block_ff   <= cmd.last_word;
         last_of_message_ff <= cmd.last_word && final_phase;
      end
   end

   assign rsp_block_word      = block_word_ff;
   assign rsp_word_index      = word_index_ff;
   assign rsp_last_of_block   = last_of_block_ff;
   assign rsp_last_of_message = last_of_message_ff;

endmodule

### hdl/hash_message_block_padder.sv
// ----------------------------------------------------------------------------
// Hash message block padder
// Gathers message bytes into 64- or 128-byte blocks and emits padded blocks
// as big-endian 64-bit words.
// ----------------------------------------------------------------------------
// An append that does not complete a block is taken while the padder stays idle.
// Each emitted word goes through a buffer read, the forming of the padded word
// (written back to the buffer when padding) and a hand-off that waits out any
// response stall. A finish emits one or two blocks.
// Reset is synchronous; it clears the byte count, mode and controller only.
module hash_message_block_padder #(
   parameter int MAX_BLOCK_BYTES = hmbp_pkg::DEF_MAX_BLOCK_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   hmbp_req_if.sink    req_ch,
   hmbp_rsp_if.source  rsp_ch,
   hmbp_csr_if.sink    csr_ch
);
   import hmbp_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ch.ready = 1'b1;

   hmbp_ctrl #(
      .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_operation (req_ch.operation),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .status        (status),
      .cmd           (cmd)
   );

   hmbp_dp #(
      .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_data_byte       (req_ch.data_byte),
      .csr_write           (csr_ch.valid & csr_ch.ready),
      .csr_block_size_mode (csr_ch.block_size_mode),
      .cmd                 (cmd),
      .status              (status),
      .rsp_block_word      (rsp_ch.block_word),
      .rsp_word_index      (rsp_ch.word_index),
      .rsp_last_of_block   (rsp_ch.last_of_block),
      .rsp_last_of_message (rsp_ch.last_of_message)
   );

endmodule

### hdl/hmbp_checker.sv
// ----------------------------------------------------------------------------
// Message block padder checker
// Port-level checks on item flow and block framing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hmbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_block_word,
   input logic [3:0]  rsp_word_index,
   input logic        rsp_last_of_block,
   input logic        rsp_last_of_message
);

   `HMBP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_word), "Stalled response item changed.")
   `HMBP_ASSERT_NEVER(a_no_overlap, clock, reset, req_ready && rsp_valid, "Request taken while a response item is pending.")
   `HMBP_ASSERT(a_msg_end, clock, reset, rsp_valid && rsp_last_of_message |-> rsp_last_of_block, "Message end not on a block end.")
   `HMBP_ASSERT(a_blk_end, clock, reset, rsp_valid && rsp_last_of_block |-> rsp_word_index == 4'd7 || rsp_word_index == 4'd15, "Block end at a wrong word index.")

endmodule

bind hash_message_block_padder hmbp_checker u_hmbp_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_block_word      (rsp_ch.block_word),
   .rsp_word_index      (rsp_ch.word_index),
   .rsp_last_of_block   (rsp_ch.last_of_block),
   .rsp_last_of_message (rsp_ch.last_of_message)
);

### sim/hash_message_block_padder_test.sv
// ----------------------------------------------------------------------------
// Message block padder testbench
// Streams message bytes and finish commands into the padder in both block
// sizes. The sender and the receiver idle and stall at random. Every padded
// block word is predicted and compared field by field with the response
// stream.
// ----------------------------------------------------------------------------
module hash_message_block_padder_test;
   import hmbp_pkg::*;

   localparam logic MODE_64       = 1'b0;
   localparam logic MODE_128      = 1'b1;
   localparam int   NARROW_BLOCK  = 64;
   localparam int   WIDE_BLOCK    = DEF_MAX_BLOCK_BYTES;
   localparam int   TOTAL_ITEMS   = 460;
   localparam int   PHASE_ITEMS   = 75;
   localparam int   SETTLE_CYCLES = 12;
   localparam int   HOLD_CYCLES   = 400;
   localparam int   STALL_LIMIT   = 2000;

   typedef struct packed {
      logic       op;
      logic [7:0] data;
   } msg_item_type;

   typedef struct packed {
      logic [63:0]             word;
      logic [WORD_INDEX_W-1:0] index;
      logic                    last_blk;
      logic                    last_msg;
   } block_word_type;

   logic clock = 1'b0;
   logic reset;

   hmbp_req_if req_ch();
   hmbp_rsp_if rsp_ch();
   hmbp_csr_if csr_ch();

   msg_item_type   pending_items[$];
   block_word_type expected_words[$];

   logic [7:0]            msg_buf [0:WIDE_BLOCK-1];
   logic [WIDE_BLOCK-1:0] buf_written = '0;
   logic [63:0]           msg_bytes   = '0;
   logic                  block_mode  = MODE_64;

   logic           send_steady   = 1'b0;
   logic           recv_steady   = 1'b0;
   logic           hold_request  = 1'b0;
   logic           hold_done     = 1'b0;
   int unsigned    hold_left     = 0;
   int unsigned    send_gap      = 0;
   int unsigned    recv_gap      = 0;
   int unsigned    idle_cycles   = 0;
   msg_item_type   drive_item;
   block_word_type want_word;

   int unsigned items_queued         = 0;
   int unsigned items_accepted       = 0;
   int unsigned words_checked        = 0;
   int unsigned messages_finished    = 0;
   int unsigned extra_pad_blocks     = 0;
   int unsigned mode_writes          = 0;
   int unsigned mid_message_switches = 0;
   int unsigned mismatches           = 0;

   hash_message_block_padder i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #4 clock = ~clock;

   function automatic void put_byte(input int unsigned pos, input logic [7:0] value);
      msg_buf[pos]     = value;
      buf_written[pos] = 1'b1;
   endfunction

   task automatic queue_block(input int unsigned blk, input logic final_block);
      block_word_type w_exp;
      for (int unsigned w = 0; w < blk / 8; w++) begin
         w_exp.word = '0;
         for (int unsigned k = 0; k < 8; k++) begin
            w_exp.word = {w_exp.word[55:0], msg_buf[w * 8 + k]};
         end
         w_exp.index    = w[WORD_INDEX_W-1:0];
         w_exp.last_blk = (w == blk / 8 - 1);
         w_exp.last_msg = final_block && w_exp.last_blk;
         expected_words.push_back(w_exp);
      end
   endtask

   task automatic absorb_item(input logic op, input logic [7:0] data);
      int unsigned blk;
      int unsigned pos;
      logic [63:0] bit_count;
      blk = (block_mode == MODE_128) ? WIDE_BLOCK : NARROW_BLOCK;
      pos = int'(msg_bytes[6:0]) & (blk - 1);
      if (op == OP_APPEND) begin
         put_byte(pos, data);
         msg_bytes = msg_bytes + 64'd1;
         if (pos == blk - 1) begin
            queue_block(blk, 1'b0);
         end
      end else begin
         bit_count = msg_bytes << 3;
         put_byte(pos, PAD_MARK);
         pos++;
         // A pad mark in the last blk/8 bytes of the block pushes the length into a block of its own.
         if (pos > blk - blk / 8) begin
            for (int unsigned k = pos; k < blk; k++) begin
               put_byte(k, 8'h00);
            end
            queue_block(blk, 1'b0);
            pos = 0;
            extra_pad_blocks++;
         end
         for (int unsigned k = pos; k < blk - LENGTH_FIELD_BYTES; k++) begin
            put_byte(k, 8'h00);
         end
         for (int unsigned k = 0; k < LENGTH_FIELD_BYTES; k++) begin
            put_byte(blk - 1 - k, bit_count[8 * k +: 8]);
         end
         queue_block(blk, 1'b1);
         msg_bytes = '0;
         messages_finished++;
      end
   endtask

   task automatic queue_item(input logic op, input logic [7:0] data);
      pending_items.push_back({op, data});
      items_queued++;
   endtask

   task automatic wait_idle();
      while (items_accepted != items_queued || expected_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_block_mode(input logic mode);
      csr_ch.valid           <= 1'b1;
      csr_ch.block_size_mode <= mode;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      block_mode = mode;
      mode_writes++;
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH at word %0d: %s is %h, expected %h", words_checked, field, got,
               want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            absorb_item(req_ch.operation, req_ch.data_byte);
            items_accepted++;
            send_gap = send_steady ? 0 : $urandom_range(0, 11);
         end
         if (send_gap != 0) begin
            req_ch.valid <= 1'b0;
            send_gap--;
         end else if (pending_items.size() != 0) begin
            drive_item = pending_items.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.operation <= drive_item.op;
            req_ch.data_byte <= drive_item.data;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap  = 0;
         hold_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", rsp_ch.block_word, 64'd0);
            end else begin
               want_word = expected_words.pop_front();
               if (rsp_ch.block_word !== want_word.word) begin
                  report_mismatch("block_word", rsp_ch.block_word, want_word.word);
               end
               if (rsp_ch.word_index !== want_word.index) begin
                  report_mismatch("word_index", 64'(rsp_ch.word_index),
                                  64'(want_word.index));
               end
               if (rsp_ch.last_of_block !== want_word.last_blk) begin
                  report_mismatch("last_of_block", 64'(rsp_ch.last_of_block),
                                  64'(want_word.last_blk));
               end
               if (rsp_ch.last_of_message !== want_word.last_msg) begin
                  report_mismatch("last_of_message", 64'(rsp_ch.last_of_message),
                                  64'(want_word.last_msg));
               end
            end
            words_checked++;
            recv_gap = recv_steady ? 0 : $urandom_range(0, 11);
         end
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done <= 1'b1;
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (recv_gap != 0) begin
            rsp_ch.ready <= 1'b0;
            recv_gap--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned phase;
      int unsigned blk;
      int unsigned len;
      int unsigned phase_end;
      logic        phase_mode;
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.operation       = OP_APPEND;
      req_ch.data_byte       = 8'h00;
      rsp_ch.ready           = 1'b0;
      csr_ch.valid           = 1'b0;
      csr_ch.block_size_mode = MODE_64;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // Empty messages and byte extremes in both block sizes.
      queue_item(OP_FINISH, 8'hFF);
      queue_item(OP_APPEND, 8'h00);
      queue_item(OP_APPEND, 8'hFF);
      queue_item(OP_FINISH, 8'h00);
      queue_item(OP_APPEND, 8'h80);
      queue_item(OP_FINISH, 8'h5A);
      wait_idle();
      write_block_mode(MODE_128);
      queue_item(OP_FINISH, 8'h00);
      queue_item(OP_APPEND, 8'hFF);
      queue_item(OP_APPEND, 8'h01);
      queue_item(OP_FINISH, 8'hFF);
      wait_idle();

      for (phase = 0; items_queued < TOTAL_ITEMS; phase++) begin
         phase_mode = (phase % 2 == 0) ? MODE_64 : MODE_128;
         // A block size change inside a message is safe only once every buffer byte is set.
         if (msg_bytes != 0 && !(&buf_written)) begin
            queue_item(OP_FINISH, 8'($urandom_range(0, 255)));
            wait_idle();
         end
         if (msg_bytes != 0 && phase_mode != block_mode) begin
            mid_message_switches++;
         end
         write_block_mode(phase_mode);
         blk         = (phase_mode == MODE_128) ? WIDE_BLOCK : NARROW_BLOCK;
         send_steady = (phase % 3 == 2);
         recv_steady = (phase % 3 == 2);
         if (phase == 1) begin
            send_steady  = 1'b1;
            recv_steady  = 1'b0;
            hold_request = 1'b1;
         end
         phase_end = items_queued + PHASE_ITEMS;
         while (items_queued < phase_end && items_queued < TOTAL_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
               repeat ($urandom_range(1, 6)) begin
                  queue_item(($urandom_range(0, 2) == 0) ? OP_FINISH : OP_APPEND,
                             8'($urandom_range(0, 255)));
               end
            end else begin
               case ($urandom_range(0, 4))
                  0: len = $urandom_range(0, 8);
                  1: len = $urandom_range(blk - blk / 8 - 2, blk - 1);
                  2: len = $urandom_range(blk - 1, blk + 1);
                  3: len = $urandom_range(0, blk - 1);
                  default: len = $urandom_range(blk, 2 * blk + 9);
               endcase
               repeat (len) queue_item(OP_APPEND, 8'($urandom_range(0, 255)));
               queue_item(OP_FINISH, 8'($urandom_range(0, 255)));
            end
         end
         if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, blk + 8)) queue_item(OP_APPEND, 8'($urandom_range(0, 255)));
         end
         wait_idle();
      end

      $display("Checked %0d block words from %0d items: %0d finished messages, %0d with an %s",
               words_checked, items_accepted, messages_finished, extra_pad_blocks,
               "extra pad block.");
      $display("Block size written %0d times, %0d inside a message, with one long output stall.",
               mode_writes, mid_message_switches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/hmbp_pkg.sv
hdl/hmbp_req_if.sv
hdl/hmbp_rsp_if.sv
hdl/hmbp_csr_if.sv
hdl/hmbp_ctrl.sv
hdl/hmbp_dp.sv
hdl/hash_message_block_padder.sv
hdl/hmbp_checker.sv
sim/hash_message_block_padder_test.sv
